// File: hdl/hvd_pkg.sv
// Shared widths, elaboration-time constant builders and the arctangent table.
`timescale 1ns / 1ps

package hvd_pkg;

  localparam int unsigned CORDIC_STAGES   = 32;
  localparam int unsigned ANGLE_FRAC_BITS = 32;

  // CORDIC x, y and z lanes, signed
  localparam int unsigned CW  = ANGLE_FRAC_BITS + 4;
  // magnitudes and squared terms, unsigned
  localparam int unsigned MW  = ANGLE_FRAC_BITS + 2;
  // square root remainder, unsigned
  localparam int unsigned SRW = 2 * ANGLE_FRAC_BITS + 2;
  // square root result, unsigned
  localparam int unsigned RTW = ANGLE_FRAC_BITS + 1;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] HALF_TURN = 64'd3600000000;

  // restoring division, elaboration only
  function automatic logic [127:0] udiv(input logic [127:0] num, input logic [127:0] den);
    logic [127:0] q;
    logic [127:0] r;
    q = '0;
    r = '0;
    for (int k = 127; k >= 0; k--) begin
      r = {r[126:0], num[k]};
      if (r >= den) begin
        r = r - den;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) at 62 fraction bits from the alternating series, rounded to the angle format
  function automatic logic [CW-1:0] atan_rom(input int unsigned i);
    logic signed [63:0] acc;
    logic [127:0]       term;
    logic [63:0]        v;
    acc = '0;
    if (i == 0) begin
      v = PI_Q60;
    end else begin
      for (int unsigned k = 0; i * (2 * k + 1) <= 62; k++) begin
        term = udiv(128'd1 << (62 - i * (2 * k + 1)), 128'(2 * k + 1));
        if (k[0]) begin
          acc = acc - $signed(term[63:0]);
        end else begin
          acc = acc + $signed(term[63:0]);
        end
      end
      v = acc;
    end
    return CW'((v + (64'd1 << (61 - ANGLE_FRAC_BITS))) >> (62 - ANGLE_FRAC_BITS));
  endfunction

  // 1 / gain^2 of the rotator at 62 fraction bits
  function automatic logic [63:0] inv_gain2(input int unsigned stages);
    logic [63:0]  g;
    logic [127:0] q;
    g = 64'd1 << 61;
    for (int unsigned i = 0; i < stages; i++) begin
      if (2 * i < 64) begin
        g = g + (g >> (2 * i));
      end
    end
    q = udiv(128'd1 << 123, 128'(g));
    return q[63:0];
  endfunction

  // degrees-to-radians scale for angles in 0.5e-7 degree units
  function automatic logic [63:0] rad_scale();
    logic [127:0] q;
    q = udiv(128'(PI_Q60) << 34, 128'(HALF_TURN));
    return q[63:0];
  endfunction

endpackage

// File: hdl/hvd_cordic_cell.sv
// One CORDIC micro-rotation, rotation or vectoring mode, registered.
`timescale 1ns / 1ps

module hvd_cordic_cell #(
  parameter int unsigned STAGE  = 0,
  parameter bit          VECTOR = 1'b0
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [hvd_pkg::CW-1:0]  x_i,
  input  logic signed [hvd_pkg::CW-1:0]  y_i,
  input  logic signed [hvd_pkg::CW-1:0]  z_i,
  output logic signed [hvd_pkg::CW-1:0]  x_o,
  output logic signed [hvd_pkg::CW-1:0]  y_o,
  output logic signed [hvd_pkg::CW-1:0]  z_o
);

  localparam int unsigned CW = hvd_pkg::CW;
  localparam logic signed [CW-1:0] Atan = $signed(hvd_pkg::atan_rom(STAGE));

  logic signed [CW-1:0] sx, sy;
  logic                 rot_pos;

  // arithmetic shift floors, as the stage needs
  assign sx = x_i >>> STAGE;
  assign sy = y_i >>> STAGE;
  // rotation steers on the residual angle, vectoring on the sign of y
  assign rot_pos = VECTOR ? y_i[CW-1] : !z_i[CW-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (rot_pos) begin
        x_o <= x_i - sy;
        y_o <= y_i + sx;
        z_o <= z_i - Atan;
      end else begin
        x_o <= x_i + sy;
        y_o <= y_i - sx;
        z_o <= z_i + Atan;
      end
    end
  end

endmodule

// File: hdl/hvd_sqrt_cell.sv
// One result bit of a restoring square root, registered.
`timescale 1ns / 1ps

module hvd_sqrt_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [hvd_pkg::RTW-1:0]   root_i,
  input  logic [hvd_pkg::SRW-1:0]   rem_i,
  output logic [hvd_pkg::RTW-1:0]   root_o,
  output logic [hvd_pkg::SRW-1:0]   rem_o
);

  localparam int unsigned SRW = hvd_pkg::SRW;
  localparam int unsigned RTW = hvd_pkg::RTW;
  localparam int unsigned TW  = SRW + 1;

  logic [TW-1:0] trial;

  // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b)
  assign trial = (TW'(root_i) << (BIT + 1)) + (TW'(1) << (2 * BIT));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (TW'(rem_i) >= trial) begin
        rem_o  <= rem_i - trial[SRW-1:0];
        root_o <= root_i | (RTW'(1) << BIT);
      end else begin
        rem_o  <= rem_i;
        root_o <= root_i;
      end
    end
  end

endmodule

// File: hdl/haversine_distance.sv
// Top level: pipelined haversine great-circle distance between two positions.
`timescale 1ns / 1ps

// Takes one position pair per clock while not stalled and returns its
// great-circle distance in millimetres, one word per clock sustained while
// the output takes each word. The words pass through CORDIC cells (one
// sine/cosine row per angle and one arctangent row) and a row of
// bit-per-cell square root stages, all advancing together. The pipeline
// holds only while its last stage carries a word and the output register is
// still waiting; empty slots keep closing up otherwise. The radius register
// may be written only while no word is in flight.
module haversine_distance #(
  parameter int unsigned CORDIC_STAGES = hvd_pkg::CORDIC_STAGES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [22:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [30:0] first_lat_i,
  input  logic signed [31:0] first_lng_i,
  input  logic signed [30:0] second_lat_i,
  input  logic signed [31:0] second_lng_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [34:0]        distance_mm_o
);

  localparam int unsigned F   = hvd_pkg::ANGLE_FRAC_BITS;
  localparam int unsigned CW  = hvd_pkg::CW;
  localparam int unsigned MW  = hvd_pkg::MW;
  localparam int unsigned SRW = hvd_pkg::SRW;
  localparam int unsigned RTW = hvd_pkg::RTW;
  localparam int unsigned AW  = 35;
  localparam int unsigned RMW = 33;
  localparam int unsigned ZW2 = F + 2;
  localparam int unsigned SPL = ZW2 / 2;
  localparam int unsigned DW  = RMW + ZW2 + 1;
  localparam int unsigned V_A = 12 + CORDIC_STAGES;
  localparam int unsigned NV  = V_A + 1 + (F + 1) + CORDIC_STAGES + 2;

  localparam logic signed [AW-1:0] TurnU     = 35'sd7200000000;
  localparam logic signed [AW-1:0] HalfU     = 35'sd3600000000;
  localparam logic signed [AW-1:0] QuarterU  = 35'sd1800000000;
  localparam logic signed [AW-1:0] NHalfU    = -35'sd3600000000;
  localparam logic signed [AW-1:0] NQuarterU = -35'sd1800000000;
  localparam logic [63:0]          RadScale  = hvd_pkg::rad_scale();
  localparam logic [63:0]          InvGain   = hvd_pkg::inv_gain2(CORDIC_STAGES);
  localparam logic [F:0]           One       = {1'b1, {F{1'b0}}};
  localparam logic [RMW-1:0]       RadiusRst = 33'd6371000000;
  localparam logic [RMW-1:0]       MmPerM    = 33'd1000;

  function automatic logic [MW-1:0] mag_of(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] n;
    n = v[CW-1] ? -v : v;
    return MW'(n);
  endfunction

  logic           adv;
  logic [NV-1:0]  vld_q;
  logic           out_valid_q;
  logic [34:0]    distance_q;
  logic [RMW-1:0] radius_mm_q;

  // hold everything only when the last stage cannot hand its word on
  assign adv         = !(vld_q[NV-1] && out_valid_q && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = out_valid_q;
  assign distance_mm_o = distance_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      radius_mm_q <= RadiusRst;
    end else begin
      if (adv) begin
        vld_q <= {vld_q[NV-2:0], in_valid_i};
      end
      if (cfg_we_i) begin
        radius_mm_q <= RMW'(cfg_wdata_i) * MmPerM;
      end
    end
  end

  // ---- angle preparation: lanes are dlat, dlng, 2*lat1, 2*lat2
  logic signed [AW-1:0] ang_q [4];
  logic signed [AW-1:0] red_d [4];
  logic signed [AW-1:0] red_q [4];
  logic [30:0]          fmag_d [4];
  logic [3:0]           fneg_d, fflip_d;
  logic [30:0]          fmag_q [4];
  logic [3:0]           fneg_q, fflip_q;
  logic [62:0]          ph_q [4];
  logic [62:0]          pl_q [4];
  logic [3:0]           pneg_q, pflip_q;
  logic signed [CW-1:0] rz_d [4];
  logic signed [CW-1:0] rz_q [4];
  logic [1:0]           rflip_q;

  always_comb begin
    logic signed [AW-1:0] r;
    logic [95:0]          rs;
    logic [CW-1:0]        zm;
    r  = '0;
    rs = '0;
    zm = '0;
    for (int l = 0; l < 4; l++) begin
      // bring into one half turn either side of zero
      if (ang_q[l] >= HalfU) begin
        red_d[l] = ang_q[l] - TurnU;
      end else if (ang_q[l] < NHalfU) begin
        red_d[l] = ang_q[l] + TurnU;
      end else begin
        red_d[l] = ang_q[l];
      end
      // mirror past a quarter turn and negate the cosine later
      r = red_q[l];
      fflip_d[l] = 1'b0;
      if (r > QuarterU) begin
        r = HalfU - r;
        fflip_d[l] = 1'b1;
      end else if (r < NQuarterU) begin
        r = NHalfU - r;
        fflip_d[l] = 1'b1;
      end
      fneg_d[l] = r[AW-1];
      fmag_d[l] = r[AW-1] ? 31'(-r) : 31'(r);
      rs = (96'(ph_q[l]) << 32) + 96'(pl_q[l]) + (96'd1 << (93 - F));
      zm = CW'(rs >> (94 - F));
      rz_d[l] = pneg_q[l] ? -$signed(zm) : $signed(zm);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ang_q[0] <= AW'(second_lat_i) - AW'(first_lat_i);
      ang_q[1] <= AW'(second_lng_i) - AW'(first_lng_i);
      ang_q[2] <= AW'(first_lat_i) + AW'(first_lat_i);
      ang_q[3] <= AW'(second_lat_i) + AW'(second_lat_i);
      for (int l = 0; l < 4; l++) begin
        red_q[l]  <= red_d[l];
        fmag_q[l] <= fmag_d[l];
        ph_q[l]   <= fmag_q[l] * RadScale[63:32];
        pl_q[l]   <= fmag_q[l] * RadScale[31:0];
        rz_q[l]   <= rz_d[l];
      end
      fneg_q  <= fneg_d;
      fflip_q <= fflip_d;
      pneg_q  <= fneg_q;
      pflip_q <= fflip_q;
      rflip_q <= pflip_q[3:2];
    end
  end

  // ---- sine and cosine rows
  logic signed [CW-1:0] rx [4][CORDIC_STAGES+1];
  logic signed [CW-1:0] ry [4][CORDIC_STAGES+1];
  logic signed [CW-1:0] rzz [4][CORDIC_STAGES+1];
  logic [1:0]           fl_q [CORDIC_STAGES];

  for (genvar l = 0; l < 4; l++) begin : g_rot_lane
    assign rx[l][0]  = CW'(One);
    assign ry[l][0]  = '0;
    assign rzz[l][0] = rz_q[l];
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
      hvd_cordic_cell #(
        .STAGE (k),
        .VECTOR(1'b0)
      ) u_cell (
        .clk_i(clk_i),
        .en_i (adv),
        .x_i  (rx[l][k]),
        .y_i  (ry[l][k]),
        .z_i  (rzz[l][k]),
        .x_o  (rx[l][k+1]),
        .y_o  (ry[l][k+1]),
        .z_o  (rzz[l][k+1])
      );
    end
  end

  // cosine fold flags travel beside the rows
  always_ff @(posedge clk_i) begin
    if (adv) begin
      fl_q[0] <= rflip_q;
      for (int k = 1; k < CORDIC_STAGES; k++) begin
        fl_q[k] <= fl_q[k-1];
      end
    end
  end

  // ---- the sum a
  logic signed [CW-1:0] c1x, c2x;
  logic                 negc1, negc2;
  logic [MW-1:0]        msl_q, msg_q, mc1_q, mc2_q;
  logic                 sub_q [7];
  logic [2*MW-1:0]      p1_q, p2_q, p3_q;
  logic [MW-1:0]        sq1_q, sq2_q, cc_q;
  logic [MW+31:0]       h1_q, l1_q, h2_q, l2_q, h3_q, l3_q;
  logic [MW-1:0]        t1_q [3];
  logic [MW-1:0]        u_q, w_q;
  logic [2*MW-1:0]      uw_q;
  logic [MW-1:0]        t2_q;
  logic [F:0]           a_q, na_q;
  logic [F:0]           a_d;
  logic signed [MW+1:0] s_d;

  assign c1x   = rx[2][CORDIC_STAGES];
  assign c2x   = rx[3][CORDIC_STAGES];
  assign negc1 = fl_q[CORDIC_STAGES-1][0] ? (!c1x[CW-1] && (c1x != '0)) : c1x[CW-1];
  assign negc2 = fl_q[CORDIC_STAGES-1][1] ? (!c2x[CW-1] && (c2x != '0)) : c2x[CW-1];

  function automatic logic [MW-1:0] gain_fix(input logic [MW+31:0] h, input logic [MW+31:0] l);
    logic [MW+64:0] t;
    t = ((MW + 65)'(h) << 32) + (MW + 65)'(l) + ((MW + 65)'(1) << 61);
    return MW'(t >> 62);
  endfunction

  always_comb begin
    s_d = sub_q[6] ? ((MW + 2)'(t1_q[2]) - (MW + 2)'(t2_q))
                   : ((MW + 2)'(t1_q[2]) + (MW + 2)'(t2_q));
    // clamp against rounding past either end
    if (s_d < 0) begin
      a_d = '0;
    end else if (s_d > $signed((MW + 2)'(One))) begin
      a_d = One;
    end else begin
      a_d = (F + 1)'(s_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      msl_q    <= mag_of(ry[0][CORDIC_STAGES]);
      msg_q    <= mag_of(ry[1][CORDIC_STAGES]);
      mc1_q    <= mag_of(c1x);
      mc2_q    <= mag_of(c2x);
      sub_q[0] <= negc1 ^ negc2;
      for (int k = 1; k < 7; k++) begin
        sub_q[k] <= sub_q[k-1];
      end
      p1_q  <= msl_q * msl_q;
      p2_q  <= msg_q * msg_q;
      p3_q  <= mc1_q * mc2_q;
      sq1_q <= MW'((p1_q + ((2 * MW)'(1) << (F - 1))) >> F);
      sq2_q <= MW'((p2_q + ((2 * MW)'(1) << (F - 1))) >> F);
      cc_q  <= MW'((p3_q + ((2 * MW)'(1) << (F - 1))) >> F);
      h1_q  <= sq1_q * InvGain[63:32];
      l1_q  <= sq1_q * InvGain[31:0];
      h2_q  <= sq2_q * InvGain[63:32];
      l2_q  <= sq2_q * InvGain[31:0];
      h3_q  <= cc_q * InvGain[63:32];
      l3_q  <= cc_q * InvGain[31:0];
      t1_q[0] <= gain_fix(h1_q, l1_q);
      w_q     <= gain_fix(h2_q, l2_q);
      u_q     <= gain_fix(h3_q, l3_q);
      uw_q    <= u_q * w_q;
      t1_q[1] <= t1_q[0];
      t2_q    <= MW'((uw_q + ((2 * MW)'(1) << (F - 1))) >> F);
      t1_q[2] <= t1_q[1];
      a_q     <= a_d;
      na_q    <= One - a_d;
    end
  end

  // ---- square roots of a and 1-a, one result bit per cell
  logic [RTW-1:0] rt [2][F+2];
  logic [SRW-1:0] rm [2][F+2];

  assign rt[0][0] = '0;
  assign rt[1][0] = '0;
  assign rm[0][0] = SRW'(a_q) << F;
  assign rm[1][0] = SRW'(na_q) << F;

  for (genvar l = 0; l < 2; l++) begin : g_sqrt_lane
    for (genvar k = 0; k <= F; k++) begin : g_sqrt
      hvd_sqrt_cell #(
        .BIT(F - k)
      ) u_cell (
        .clk_i (clk_i),
        .en_i  (adv),
        .root_i(rt[l][k]),
        .rem_i (rm[l][k]),
        .root_o(rt[l][k+1]),
        .rem_o (rm[l][k+1])
      );
    end
  end

  // ---- central angle row
  logic signed [CW-1:0] vx [CORDIC_STAGES+1];
  logic signed [CW-1:0] vy [CORDIC_STAGES+1];
  logic signed [CW-1:0] vz [CORDIC_STAGES+1];

  assign vx[0] = CW'(rt[1][F+1]);
  assign vy[0] = CW'(rt[0][F+1]);
  assign vz[0] = '0;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_vec
    hvd_cordic_cell #(
      .STAGE (k),
      .VECTOR(1'b1)
    ) u_cell (
      .clk_i(clk_i),
      .en_i (adv),
      .x_i  (vx[k]),
      .y_i  (vy[k]),
      .z_i  (vz[k]),
      .x_o  (vx[k+1]),
      .y_o  (vy[k+1]),
      .z_o  (vz[k+1])
    );
  end

  // ---- scale by radius, round to millimetres
  logic signed [CW-1:0]   zf;
  logic [ZW2-1:0]         z2_q;
  logic [RMW+ZW2-SPL-1:0] fh_q;
  logic [RMW+SPL-1:0]     flo_q;
  logic [DW-1:0]          ds;

  assign zf = vz[CORDIC_STAGES];
  assign ds = (DW'(fh_q) << SPL) + DW'(flo_q) + (DW'(1) << (F - 1));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // drop a slightly negative angle to zero, then double it
      z2_q  <= zf[CW-1] ? '0 : (ZW2'(zf) << 1);
      fh_q  <= radius_mm_q * z2_q[ZW2-1:SPL];
      flo_q <= radius_mm_q * z2_q[SPL-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= vld_q[NV-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      distance_q <= 35'(ds >> F);
    end
  end

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input held without a waiting result word");

  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[V_A] |-> (a_q <= One))
    else $error("haversine sum above one after clamp");

  a_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(vld_q[NV-1]))
    else $error("result word appeared without a finished pipeline word");

endmodule
